// ===== hw/rtl/phrase_match_line_column_assert.svh =====
// Assertion macros for the phrase matcher.
`ifndef PHRASE_MATCH_LINE_COLUMN_ASSERT_SVH
`define PHRASE_MATCH_LINE_COLUMN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phrase matcher check failed");

// Next-cycle implication, disabled during reset.
`define PLMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phrase matcher check failed");

`endif

// ===== hw/rtl/plmc_pkg.sv =====
// Shared types and constants for the phrase matcher.
package plmc_pkg;

  localparam int MAX_PHRASE     = 32;
  localparam int LINE_BITS      = 24;
  localparam int COLUMN_BITS    = 16;
  localparam int LEN_BITS       = 6;
  localparam int PHRASE_BYTES   = 32;
  localparam int PHRASE_WORDS   = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHRASE_LENGTH  = 3'd0,
    REG_BYTES_0_7      = 3'd1,
    REG_BYTES_8_15     = 3'd2,
    REG_BYTES_16_23    = 3'd3,
    REG_BYTES_24_31    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
  } match_item_t;

  typedef struct packed {
    logic                   valid;
    logic [7:0]             data;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } cell_data_t;

endpackage

// ===== hw/rtl/plmc_cell.sv =====
// One window cell: holds a byte with its position and compares the incoming byte.
module plmc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 flush,
  input  plmc_pkg::cell_data_t feed,
  input  logic [7:0]           expected,
  input  logic                 compare_en,
  output plmc_pkg::cell_data_t entry,
  output logic                 match_ok
);

  logic                             held_valid;
  logic [7:0]                       held_data;
  logic [plmc_pkg::LINE_BITS-1:0]   held_line;
  logic [plmc_pkg::COLUMN_BITS-1:0] held_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (shift) begin
      held_valid <= feed.valid & ~flush;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held_data   <= feed.data;
      held_line   <= feed.line;
      held_column <= feed.column;
    end
  end

  assign entry    = '{valid: held_valid, data: held_data, line: held_line,
                      column: held_column};
  assign match_ok = ~compare_en | (feed.valid & (feed.data == expected));

endmodule

// ===== hw/rtl/phrase_match_line_column.sv =====
// Phrase matcher top level: window cell chain, position counters, result buffer.
// A match is registered into match_item when its last byte is accepted, or into the skid entry if output is stalled.
// Throughput: one text byte per cycle while text_stall is low; text_stall rises only while two results wait.
// Reset: rst (synchronous) empties the window and result buffer, sets line and
// column to 1, phrase_length to 1 and phrase bytes to 0. No clearing pass.
`include "phrase_match_line_column_assert.svh"

module phrase_match_line_column #(
  parameter int MAX_PHRASE = plmc_pkg::MAX_PHRASE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 text_valid,
  output logic                                 text_stall,
  input  plmc_pkg::text_item_t                 text_item,
  output logic                                 match_valid,
  input  logic                                 match_stall,
  output plmc_pkg::match_item_t                match_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plmc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [plmc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int LenW = plmc_pkg::LEN_BITS + 1;

  logic [plmc_pkg::LEN_BITS-1:0]                                  phrase_length;
  logic [plmc_pkg::PHRASE_WORDS-1:0][plmc_pkg::CFG_DATA_BITS-1:0] phrase_words;

  logic [plmc_pkg::LINE_BITS-1:0]   cur_line;
  logic [plmc_pkg::COLUMN_BITS-1:0] cur_column;
  logic [plmc_pkg::LEN_BITS-1:0]    holdoff;

  logic                  skid_valid;
  plmc_pkg::match_item_t skid_item;

  logic             accept;
  logic             flush;
  logic             hit;
  logic             out_take;
  logic             at_origin;
  logic [LenW-1:0]  len_ext;
  logic [LenW-1:0]  len_eff;

  plmc_pkg::cell_data_t       feed  [MAX_PHRASE];
  plmc_pkg::cell_data_t       entry [MAX_PHRASE];
  logic [MAX_PHRASE-1:0]      cell_ok;
  logic [MAX_PHRASE-1:0]      sel;
  plmc_pkg::match_item_t      found;

  assign cfg_ready  = 1'b1;
  assign text_stall = skid_valid;
  assign accept     = text_valid & ~text_stall;
  assign flush      = text_item.end_of_text;
  assign out_take   = match_valid & ~match_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_length <= plmc_pkg::LEN_BITS'(1);
      phrase_words  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        plmc_pkg::REG_PHRASE_LENGTH: phrase_length <= cfg_data[plmc_pkg::LEN_BITS-1:0];
        plmc_pkg::REG_BYTES_0_7:     phrase_words[0] <= cfg_data;
        plmc_pkg::REG_BYTES_8_15:    phrase_words[1] <= cfg_data;
        plmc_pkg::REG_BYTES_16_23:   phrase_words[2] <= cfg_data;
        plmc_pkg::REG_BYTES_24_31:   phrase_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_ext = {1'b0, phrase_length};
  assign len_eff = (len_ext > LenW'(MAX_PHRASE)) ? LenW'(MAX_PHRASE) : len_ext;

  assign feed[0] = '{valid: 1'b1, data: text_item.text_byte, line: cur_line,
                     column: cur_column};

  for (genvar w = 0; w < MAX_PHRASE; w++) begin : g_cell
    logic [LenW-1:0] exp_idx;
    logic [7:0]      expected;
    logic            compare_en;

    if (w > 0) begin : g_link
      assign feed[w] = entry[w-1];
    end

    assign compare_en = LenW'(w) < len_eff;
    assign exp_idx    = len_eff - LenW'(w) - LenW'(1);
    assign expected   = (exp_idx < LenW'(plmc_pkg::PHRASE_BYTES))
                        ? phrase_words[exp_idx[4:3]][8*exp_idx[2:0] +: 8] : 8'h00;
    assign sel[w]     = (LenW'(w) + LenW'(1)) == len_eff;

    plmc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .flush      (flush),
      .feed       (feed[w]),
      .expected   (expected),
      .compare_en (compare_en),
      .entry      (entry[w]),
      .match_ok   (cell_ok[w])
    );
  end

  always_comb begin
    found = '0;
    for (int w = 0; w < MAX_PHRASE; w++) begin
      if (sel[w]) begin
        found.start_line   = found.start_line | feed[w].line;
        found.start_column = found.start_column | feed[w].column;
      end
    end
  end

  assign hit = (len_eff != '0) && (&cell_ok) && (holdoff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line   <= plmc_pkg::LINE_BITS'(1);
      cur_column <= plmc_pkg::COLUMN_BITS'(1);
      holdoff    <= '0;
    end else if (accept) begin
      if (flush) begin
        cur_line   <= plmc_pkg::LINE_BITS'(1);
        cur_column <= plmc_pkg::COLUMN_BITS'(1);
        holdoff    <= '0;
      end else begin
        if (text_item.text_byte == plmc_pkg::NEWLINE) begin
          if (cur_line != '1) begin
            cur_line <= cur_line + plmc_pkg::LINE_BITS'(1);
          end
          cur_column <= plmc_pkg::COLUMN_BITS'(1);
        end else if (cur_column != '1) begin
          cur_column <= cur_column + plmc_pkg::COLUMN_BITS'(1);
        end
        if (holdoff != '0) begin
          holdoff <= holdoff - plmc_pkg::LEN_BITS'(1);
        end else if (hit) begin
          holdoff <= plmc_pkg::LEN_BITS'(len_eff - LenW'(1));
        end
      end
    end
  end

  assign at_origin = (holdoff == '0) && (cur_line == plmc_pkg::LINE_BITS'(1)) &&
                     (cur_column == plmc_pkg::COLUMN_BITS'(1));

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        match_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end
    end else if (accept && hit) begin
      if (!match_valid || out_take) begin
        match_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        match_item <= skid_item;
      end
    end else if (accept && hit) begin
      if (!match_valid || out_take) begin
        match_item <= found;
      end else begin
        skid_item <= found;
      end
    end
  end

  `PLMC_ASSERT_NOW(a_skid_behind_out, skid_valid, match_valid)
  `PLMC_ASSERT_NEXT(a_hit_delivers, accept && hit, match_valid)
  `PLMC_ASSERT_NEXT(a_flush_clears, accept && flush, at_origin)
  `PLMC_ASSERT_NOW(a_holdoff_blocks, holdoff != '0, !hit)

endmodule
